/* rtl/core/oai_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array package
// Shared widths, action and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package oai_pkg;

    // Field widths of the request and response words
    localparam int WORD_W    = 64;
    localparam int POS_W     = 5;
    localparam int ACT_W     = 3;
    localparam int CNT_OUT_W = 5;
    localparam int STAT_W    = 2;

    // Default capacity of the array
    localparam int DEPTH_DEF = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP_BACK = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Kind of work an accepted word needs
    typedef enum logic [1:0] {
        K_NONE,     // error or unused action: answer only
        K_UP,       // read sweep toward the back, close a gap
        K_DOWN,     // read sweep toward the front, open a gap, then put
        K_PUT       // single write
    } t_kind;

    // Element count change applied when the answer is issued
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic up_step;
        logic dn_step;
        logic put;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_kind new_kind;
        logic  up_done;
        logic  dn_done;
        logic  out_free;
    } t_dp_stat;

endpackage

/* rtl/core/oai_if.sv */
// ----------------------------------------------------------------------------
// Ordered array channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface oai_req_if
    import oai_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;

    modport source (output valid, output action, output position, output word_in,
                    input ready);
    modport sink   (input valid, input action, input position, input word_in,
                    output ready);
endinterface

interface oai_rsp_if
    import oai_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_OUT_W-1:0]     count;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output word_out, output count, output status,
                    input ready);
    modport sink   (input valid, input word_out, input count, input status,
                    output ready);
endinterface

/* rtl/core/ordered_array_insert_remove.sv */
// One word is in flight at a time; the single RAM read/write port pair moves
// one element a cycle. Reset empties the array at once; the RAM itself needs
// no clearing pass.
// ----------------------------------------------------------------------------
// Ordered array with insert and remove
// Fixed-capacity ordered array of signed 64-bit words with seven actions.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove
    import oai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    oai_req_if.sink   i_req,
    oai_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    // Sequencer
    oai_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Pointers, decode and answer
    oai_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_req.action),
        .i_position    (i_req.position),
        .i_word_in     (i_req.word_in),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_word_out    (o_rsp.word_out),
        .o_count       (o_rsp.count),
        .o_status      (o_rsp.status)
    );

    // Element store
    oai_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

/* rtl/core/oai_ram.sv */
// ----------------------------------------------------------------------------
// Ordered array RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oai_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/oai_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered array controller
// Sequences accept, element sweeps, the final write and the answer.
// ----------------------------------------------------------------------------
module oai_ctrl
    import oai_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP_UP,
        S_SWEEP_DN,
        S_PUT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_stat.new_kind)
                        K_UP:    n_state = S_SWEEP_UP;
                        K_DOWN:  n_state = S_SWEEP_DN;
                        K_PUT:   n_state = S_PUT;
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_SWEEP_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.up_done) begin
                    n_state = S_FINISH;
                end
            end
            S_SWEEP_DN: begin
                o_cmd.dn_step = 1'b1;
                if (i_stat.dn_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/oai_dp.sv */
// ----------------------------------------------------------------------------
// Ordered array datapath
// Decodes a request, walks element pointers over the RAM, holds the answer.
// ----------------------------------------------------------------------------
module oai_dp
    import oai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    output logic                     o_ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_ram_wr_addr,
    output logic [WORD_W-1:0]        o_ram_wr_data,
    output logic                     o_ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_ram_rd_addr,
    input  logic [WORD_W-1:0]        i_ram_rd_data,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [CNT_OUT_W-1:0]     o_count,
    output logic [STAT_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // Control registers
    logic [CW-1:0]     r_count,   n_count;
    logic [CW-1:0]     r_rd_ptr,  n_rd_ptr;
    logic [CW-1:0]     r_lim,     n_lim;
    logic [CW-1:0]     r_wr_ptr,  n_wr_ptr;
    logic [AW-1:0]     r_pipe_addr, n_pipe_addr;
    logic              r_pipe_vld, n_pipe_vld;
    logic              r_first,   n_first;
    logic              r_capture, n_capture;
    t_cnt_op           r_cnt_op,  n_cnt_op;
    logic [STAT_W-1:0] r_status,  n_status;
    logic              r_out_vld, n_out_vld;

    // Payload registers
    logic [WORD_W-1:0]    r_word,       n_word;
    logic [WORD_W-1:0]    r_result,     n_result;
    logic [WORD_W-1:0]    r_out_word,   n_out_word;
    logic [CNT_OUT_W-1:0] r_out_count,  n_out_count;
    logic [STAT_W-1:0]    r_out_status, n_out_status;

    // Request decode
    logic [PW-1:0]     pos_x;
    logic [PW-1:0]     cnt_x;
    logic [CW-1:0]     pos_c;
    logic              is_full;
    logic              is_empty;
    logic [STAT_W-1:0] l_status;
    t_kind             l_kind;
    logic [CW-1:0]     l_start;
    logic [CW-1:0]     l_lim;
    logic [CW-1:0]     l_wr;
    logic              l_capture;
    t_cnt_op           l_cnt_op;

    // Sweep and count helpers
    logic          up_issue;
    logic          dn_issue;
    logic [CW-1:0] rd_dec;
    logic [CW-1:0] cnt_new;
    logic [PW-1:0] cnt_new_x;

    assign pos_x    = PW'(i_position);
    assign cnt_x    = PW'(r_count);
    assign pos_c    = pos_x[CW-1:0];
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Classify the request against the current element count
    always_comb begin
        l_status  = ST_OK;
        l_kind    = K_NONE;
        l_start   = '0;
        l_lim     = '0;
        l_wr      = '0;
        l_capture = 1'b0;
        l_cnt_op  = CNT_HOLD;
        unique case (i_action)
            ACT_PUSH: begin
                if (is_full) begin
                    l_status = ST_FULL;
                end else begin
                    l_kind   = K_PUT;
                    l_wr     = r_count;
                    l_cnt_op = CNT_INC;
                end
            end
            ACT_POP_BACK: begin
                if (is_empty) begin
                    l_status = ST_EMPTY;
                end else begin
                    l_kind    = K_UP;
                    l_start   = r_count - 1'b1;
                    l_lim     = r_count;
                    l_wr      = r_count - 1'b1;
                    l_capture = 1'b1;
                    l_cnt_op  = CNT_DEC;
                end
            end
            ACT_POP_HEAD: begin
                if (is_empty) begin
                    l_status = ST_EMPTY;
                end else begin
                    l_kind    = K_UP;
                    l_lim     = r_count;
                    l_capture = 1'b1;
                    l_cnt_op  = CNT_DEC;
                end
            end
            ACT_INSERT: begin
                if (pos_x > cnt_x) begin
                    l_status = ST_RANGE;
                end else if (is_full) begin
                    l_status = ST_FULL;
                end else begin
                    l_kind   = K_DOWN;
                    l_start  = r_count;
                    l_lim    = pos_c;
                    l_wr     = pos_c;
                    l_cnt_op = CNT_INC;
                end
            end
            ACT_REMOVE: begin
                if (pos_x >= cnt_x) begin
                    l_status = ST_RANGE;
                end else begin
                    l_kind   = K_UP;
                    l_start  = pos_c;
                    l_lim    = r_count;
                    l_wr     = pos_c;
                    l_cnt_op = CNT_DEC;
                end
            end
            ACT_READ: begin
                if (pos_x >= cnt_x) begin
                    l_status = ST_RANGE;
                end else begin
                    l_kind    = K_UP;
                    l_start   = pos_c;
                    l_lim     = pos_c + 1'b1;
                    l_wr      = pos_c;
                    l_capture = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (pos_x >= cnt_x) begin
                    l_status = ST_RANGE;
                end else begin
                    l_kind = K_PUT;
                    l_wr   = pos_c;
                end
            end
            default: begin
                l_status = ST_OK;
            end
        endcase
    end

    assign up_issue = (r_rd_ptr < r_lim);
    assign dn_issue = (r_rd_ptr > r_lim);
    assign rd_dec   = r_rd_ptr - 1'b1;

    // Drive RAM ports: one read and one write per cycle
    always_comb begin
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = r_rd_ptr[AW-1:0];
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_wr_ptr[AW-1:0];
        o_ram_wr_data = i_ram_rd_data;
        if (i_cmd.up_step) begin
            o_ram_rd_en = up_issue;
            o_ram_wr_en = r_pipe_vld && !r_first;
        end
        if (i_cmd.dn_step) begin
            o_ram_rd_en   = dn_issue;
            o_ram_rd_addr = rd_dec[AW-1:0];
            o_ram_wr_en   = r_pipe_vld;
            o_ram_wr_addr = r_pipe_addr;
        end
        if (i_cmd.put) begin
            o_ram_wr_en   = 1'b1;
            o_ram_wr_data = r_word;
        end
    end

    // New element count for the answer
    always_comb begin
        unique case (r_cnt_op)
            CNT_INC: cnt_new = r_count + 1'b1;
            CNT_DEC: cnt_new = r_count - 1'b1;
            default: cnt_new = r_count;
        endcase
    end

    assign cnt_new_x = PW'(cnt_new);

    // Next values of pointers, result and answer
    always_comb begin
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_lim        = r_lim;
        n_wr_ptr     = r_wr_ptr;
        n_pipe_addr  = r_pipe_addr;
        n_pipe_vld   = r_pipe_vld;
        n_first      = r_first;
        n_capture    = r_capture;
        n_cnt_op     = r_cnt_op;
        n_status     = r_status;
        n_out_vld    = r_out_vld;
        n_word       = r_word;
        n_result     = r_result;
        n_out_word   = r_out_word;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;

        // Latch an accepted request
        if (i_cmd.load) begin
            n_rd_ptr   = l_start;
            n_lim      = l_lim;
            n_wr_ptr   = l_wr;
            n_pipe_vld = 1'b0;
            n_first    = 1'b1;
            n_capture  = l_capture;
            n_cnt_op   = l_cnt_op;
            n_status   = l_status;
            n_word     = i_word_in;
            n_result   = '0;
        end

        // Sweep toward the back: first word is the one taken out
        if (i_cmd.up_step) begin
            if (up_issue) begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
            n_pipe_vld = up_issue;
            if (r_pipe_vld) begin
                if (r_first) begin
                    n_first = 1'b0;
                    if (r_capture) begin
                        n_result = i_ram_rd_data;
                    end
                end else begin
                    n_wr_ptr = r_wr_ptr + 1'b1;
                end
            end
        end

        // Sweep toward the front: each word lands one slot higher
        if (i_cmd.dn_step) begin
            if (dn_issue) begin
                n_rd_ptr    = rd_dec;
                n_pipe_addr = r_rd_ptr[AW-1:0];
            end
            n_pipe_vld = dn_issue;
        end

        // Issue the answer, drop it once taken
        if (i_cmd.out_load) begin
            n_count      = cnt_new;
            n_out_vld    = 1'b1;
            n_out_word   = r_result;
            n_out_count  = cnt_new_x[CNT_OUT_W-1:0];
            n_out_status = r_status;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_ptr   <= '0;
            r_lim      <= '0;
            r_wr_ptr   <= '0;
            r_pipe_vld <= 1'b0;
            r_first    <= 1'b0;
            r_capture  <= 1'b0;
            r_cnt_op   <= CNT_HOLD;
            r_status   <= ST_OK;
            r_out_vld  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rd_ptr   <= n_rd_ptr;
            r_lim      <= n_lim;
            r_wr_ptr   <= n_wr_ptr;
            r_pipe_vld <= n_pipe_vld;
            r_first    <= n_first;
            r_capture  <= n_capture;
            r_cnt_op   <= n_cnt_op;
            r_status   <= n_status;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pipe_addr  <= n_pipe_addr;
        r_word       <= n_word;
        r_result     <= n_result;
        r_out_word   <= n_out_word;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_stat.new_kind = l_kind;
    assign o_stat.up_done  = !up_issue && !r_pipe_vld;
    assign o_stat.dn_done  = !dn_issue && !r_pipe_vld;
    assign o_stat.out_free = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_word_out  = r_out_word;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Ordered array testbench
// Drives push, pop, insert, remove, read, write and unused action words
// through the request channel. It runs a short scripted sequence first, then
// random words with alternating fill and drain phases, so that the array
// often reaches both empty and full. A shadow copy of the array predicts
// every response word, and each response is compared field by field in
// arrival order. Both channels idle at random, except in one long steady
// stretch.
// ----------------------------------------------------------------------------
module testbench
    import oai_pkg::*;
();

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RAND_WORDS = 1000;
    localparam int CYCLE_CAP  = 500000;
    localparam int SCRIPT_MAX = 64;

    localparam logic [ACT_W-1:0]         ACT_UNUSED = 3'd7;
    localparam logic signed [WORD_W-1:0] W_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WORD_W-1:0] W_MIN      = 64'sh8000_0000_0000_0000;
    localparam logic signed [WORD_W-1:0] W_ONES     = -64'sd1;

    // One request word, with an optional hand-written answer
    typedef struct packed {
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
        int                       reps;
        bit                       typed;
        logic signed [WORD_W-1:0] want_word;
        logic [CNT_OUT_W-1:0]     want_count;
        logic [STAT_W-1:0]        want_status;
    } t_row;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [CNT_OUT_W-1:0]     count;
        logic [STAT_W-1:0]        status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    oai_req_if req_ch ();
    oai_rsp_if rsp_ch ();

    ordered_array_insert_remove #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow array and its answers still to arrive
    logic signed [WORD_W-1:0] shelf [DEPTH];
    int                       shelf_fill;
    t_answer                  pending_answers [$];

    t_row        cur_row;
    t_row        script [SCRIPT_MAX];
    int          script_len;
    bit          steady;
    int          mismatches;
    int unsigned cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // Append one row to the stimulus table
    function automatic void add_row(input t_row r);
        script[script_len] = r;
        script_len++;
    endfunction

    // Drop the element at idx and shift the tail toward the front
    function automatic void close_slot(input int idx);
        int k;
        for (k = idx; k + 1 < shelf_fill; k++)
            shelf[k] = shelf[k + 1];
        shelf[shelf_fill - 1] = '0;
        shelf_fill--;
    endfunction

    // Apply one request word to the shadow array and return its answer
    function automatic t_answer apply_request(input logic [ACT_W-1:0] act,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [WORD_W-1:0] word);
        t_answer a;
        int      k;
        int      p;
        a.word_out = '0;
        a.status   = ST_OK;
        p = int'(pos);
        case (act)
            ACT_PUSH: begin
                if (shelf_fill >= DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    shelf[shelf_fill] = word;
                    shelf_fill++;
                end
            end
            ACT_POP_BACK: begin
                if (shelf_fill == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    a.word_out = shelf[shelf_fill - 1];
                    shelf[shelf_fill - 1] = '0;
                    shelf_fill--;
                end
            end
            ACT_POP_HEAD: begin
                if (shelf_fill == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    a.word_out = shelf[0];
                    close_slot(0);
                end
            end
            ACT_INSERT: begin
                // Range is checked before capacity
                if (p > shelf_fill) begin
                    a.status = ST_RANGE;
                end else if (shelf_fill >= DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    for (k = shelf_fill; k > p; k--)
                        shelf[k] = shelf[k - 1];
                    shelf[p] = word;
                    shelf_fill++;
                end
            end
            ACT_REMOVE: begin
                if (p >= shelf_fill) a.status = ST_RANGE;
                else close_slot(p);
            end
            ACT_READ: begin
                if (p >= shelf_fill) a.status = ST_RANGE;
                else a.word_out = shelf[p];
            end
            ACT_WRITE: begin
                if (p >= shelf_fill) a.status = ST_RANGE;
                else shelf[p] = word;
            end
            default: ;
        endcase
        a.count = shelf_fill[CNT_OUT_W-1:0];
        return a;
    endfunction

    function automatic t_row plan(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                  input logic signed [WORD_W-1:0] word, input int reps);
        t_row r;
        r      = '0;
        r.act  = act;
        r.pos  = pos;
        r.word = word;
        r.reps = reps;
        return r;
    endfunction

    function automatic t_row known(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                   input logic signed [WORD_W-1:0] word,
                                   input logic signed [WORD_W-1:0] want_word,
                                   input logic [CNT_OUT_W-1:0] want_count,
                                   input logic [STAT_W-1:0] want_status);
        t_row r;
        r             = plan(act, pos, word, 1);
        r.typed       = 1'b1;
        r.want_word   = want_word;
        r.want_count  = want_count;
        r.want_status = want_status;
        return r;
    endfunction

    // Random word, leaning toward growth or shrinkage
    function automatic t_row random_request(input bit filling);
        t_row r;
        int   roll;
        r      = '0;
        r.reps = 1;
        roll   = $urandom_range(99);
        if (filling) begin
            if      (roll < 40) r.act = ACT_PUSH;
            else if (roll < 65) r.act = ACT_INSERT;
            else if (roll < 75) r.act = ACT_WRITE;
            else if (roll < 85) r.act = ACT_READ;
            else if (roll < 90) r.act = ACT_POP_BACK;
            else if (roll < 94) r.act = ACT_POP_HEAD;
            else if (roll < 98) r.act = ACT_REMOVE;
            else                r.act = ACT_UNUSED;
        end else begin
            if      (roll < 5)  r.act = ACT_PUSH;
            else if (roll < 12) r.act = ACT_INSERT;
            else if (roll < 20) r.act = ACT_WRITE;
            else if (roll < 30) r.act = ACT_READ;
            else if (roll < 50) r.act = ACT_POP_BACK;
            else if (roll < 70) r.act = ACT_POP_HEAD;
            else if (roll < 97) r.act = ACT_REMOVE;
            else                r.act = ACT_UNUSED;
        end
        // Mostly indexes that can land in range, now and then any index
        if ($urandom_range(19) == 0) r.pos = POS_W'($urandom_range(31));
        else                         r.pos = POS_W'($urandom_range(DEPTH));
        case ($urandom_range(19))
            0:       r.word = W_MAX;
            1:       r.word = W_MIN;
            2:       r.word = '0;
            3:       r.word = W_ONES;
            default: r.word = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // Present one word and hold it until accepted
    task automatic offer_request(input t_row r);
        int gap;
        gap = 0;
        if (!steady)
            while (gap < 12 && $urandom_range(99) < 35) gap++;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= r.act;
        req_ch.position <= r.pos;
        req_ch.word_in  <= r.word;
        cur_row         <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stall the response side at random
    always @(posedge i_clk) begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 35);
    end

    // Record accepted requests, check accepted responses
    always @(posedge i_clk) begin : watch
        t_answer want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                want = apply_request(req_ch.action, req_ch.position, req_ch.word_in);
                if (cur_row.typed) begin
                    want.word_out = cur_row.want_word;
                    want.count    = cur_row.want_count;
                    want.status   = cur_row.want_status;
                end
                pending_answers.insert(pending_answers.size(), want);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_answers.size() == 0) begin
                    flag_mismatch("response word with nothing expected", rsp_ch.word_out, '0);
                end else begin
                    want = pending_answers[0];
                    pending_answers.delete(0);
                    if (rsp_ch.word_out !== want.word_out)
                        flag_mismatch("word_out", rsp_ch.word_out, want.word_out);
                    if (rsp_ch.count !== want.count)
                        flag_mismatch("count", 64'(rsp_ch.count), 64'(want.count));
                    if (rsp_ch.status !== want.status)
                        flag_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                end
            end
        end
    end

    initial begin
        t_row r;
        int   i;
        int   k;
        int   n;
        for (i = 0; i < DEPTH; i++) shelf[i] = '0;
        shelf_fill      = 0;
        script_len      = 0;
        mismatches      = 0;
        cycle_count     = 0;
        steady          = 1'b0;
        cur_row         = '0;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = '0;
        req_ch.position = '0;
        req_ch.word_in  = '0;
        rsp_ch.ready    = 1'b0;

        // Errors on the empty array, the unused action, then a small fill
        add_row(known(ACT_POP_BACK, 5'd0, 64'sd0, '0, 5'd0, ST_EMPTY));
        add_row(known(ACT_READ, 5'd0, 64'sd0, '0, 5'd0, ST_RANGE));
        add_row(known(ACT_REMOVE, 5'd0, 64'sd0, '0, 5'd0, ST_RANGE));
        add_row(known(ACT_WRITE, 5'd0, W_MAX, '0, 5'd0, ST_RANGE));
        add_row(known(ACT_INSERT, 5'd1, W_MAX, '0, 5'd0, ST_RANGE));
        add_row(known(ACT_UNUSED, 5'd0, W_ONES, '0, 5'd0, ST_OK));
        add_row(known(ACT_INSERT, 5'd0, W_MAX, '0, 5'd1, ST_OK));
        add_row(known(ACT_PUSH, 5'd0, W_MIN, '0, 5'd2, ST_OK));
        add_row(known(ACT_PUSH, 5'd0, W_ONES, '0, 5'd3, ST_OK));
        add_row(known(ACT_READ, 5'd1, 64'sd0, W_MIN, 5'd3, ST_OK));
        add_row(plan(ACT_INSERT, 5'd3, 64'sh5555_5555_5555_5555, 1));
        add_row(plan(ACT_INSERT, 5'd1, 64'shAAAA_AAAA_AAAA_AAAA, 1));
        add_row(known(ACT_WRITE, 5'd31, W_MAX, '0, 5'd5, ST_RANGE));
        add_row(plan(ACT_REMOVE, 5'd1, 64'sd0, 1));
        add_row(plan(ACT_POP_HEAD, 5'd0, 64'sd0, 1));
        add_row(plan(ACT_UNUSED, 5'd16, W_MIN, 1));
        add_row(plan(ACT_WRITE, 5'd0, 64'sh0123_4567_89AB_CDEF, 1));
        // Fill past capacity, then hit the full cases
        add_row(plan(ACT_PUSH, 5'd0, 64'sh1000, 16));
        add_row(known(ACT_PUSH, 5'd0, W_MAX, '0, 5'd16, ST_FULL));
        add_row(known(ACT_INSERT, 5'd16, W_MAX, '0, 5'd16, ST_FULL));
        add_row(known(ACT_INSERT, 5'd17, W_MAX, '0, 5'd16, ST_RANGE));
        add_row(plan(ACT_REMOVE, 5'd0, 64'sd0, 1));
        add_row(plan(ACT_INSERT, 5'd0, W_MIN, 1));
        add_row(plan(ACT_READ, 5'd15, 64'sd0, 1));
        // Drain from both ends
        add_row(plan(ACT_POP_BACK, 5'd0, 64'sd0, 8));
        add_row(plan(ACT_POP_HEAD, 5'd0, 64'sd0, 8));
        add_row(known(ACT_POP_HEAD, 5'd0, 64'sd0, '0, 5'd0, ST_EMPTY));

        // Hold reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scripted words; repeated rows step the data word
        for (i = 0; i < script_len; i++) begin
            for (k = 0; k < script[i].reps; k++) begin
                r      = script[i];
                r.word = script[i].word + WORD_W'(k);
                offer_request(r);
            end
        end

        // Random words: alternate fill and drain phases, one steady stretch
        for (n = 0; n < RAND_WORDS; n++) begin
            steady = (n >= 400 && n < 600);
            r = random_request(((n / 50) % 2) == 0);
            offer_request(r);
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        // Let the last answers drain
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/oai_pkg.sv
rtl/core/oai_if.sv
rtl/core/oai_ram.sv
rtl/core/oai_ctrl.sv
rtl/core/oai_dp.sv
rtl/core/ordered_array_insert_remove.sv
dv/testbench.sv
